/* hw/rtl/rmd_pkg.sv */
`default_nettype none
package rmd_pkg;
    localparam int unsigned NumRounds = 80;

    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_sel;
    typedef logic [4:0]  t_rot;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_line;

    typedef struct packed {
        logic       valid;
        t_line      left;
        t_line      right;
        t_word [15:0] w;
    } t_slot;

    localparam t_word IV0 = 32'h67452301;
    localparam t_word IV1 = 32'hEFCDAB89;
    localparam t_word IV2 = 32'h98BADCFE;
    localparam t_word IV3 = 32'h10325476;
    localparam t_word IV4 = 32'hC3D2E1F0;

    localparam logic [3:0] SEL_L [80] = '{
        0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
        7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
        3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
        1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
        4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
    localparam logic [3:0] SEL_R [80] = '{
        5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
        6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
        15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
        8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
        12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
    localparam logic [4:0] ROT_L [80] = '{
        11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
        7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
        11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
        11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
        9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
    localparam logic [4:0] ROT_R [80] = '{
        8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
        9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
        9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
        15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
        8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
    localparam t_word K_L [5] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1,
                                  32'h8F1BBCDC, 32'hA953FD4E};
    localparam t_word K_R [5] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3,
                                  32'h7A6D76E9, 32'h00000000};

    function automatic t_word rotl(input t_word x, input t_rot n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic t_word bool_fn(input logic [2:0] g, input t_word x,
                                      input t_word y, input t_word z);
        case (g)
            3'd0:    return x ^ y ^ z;
            3'd1:    return (x & y) | (~x & z);
            3'd2:    return (x | ~y) ^ z;
            3'd3:    return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/rmd_round_cell.sv */
`default_nettype none
module rmd_round_cell #(
    parameter int unsigned ROUND = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  rmd_pkg::t_slot     i_slot,
    output rmd_pkg::t_slot     o_slot
);
    import rmd_pkg::*;

    localparam logic [2:0] GrpL = 3'(ROUND / 16);
    localparam logic [2:0] GrpR = 3'(4 - ROUND / 16);
    localparam t_rot RotL = ROT_L[ROUND];
    localparam t_rot RotR = ROT_R[ROUND];
    localparam t_word KL = K_L[ROUND / 16];
    localparam t_word KR = K_R[ROUND / 16];
    localparam t_sel SelL = SEL_L[ROUND];
    localparam t_sel SelR = SEL_R[ROUND];

    t_slot r_slot;
    t_slot n_slot;
    t_word w_tl;
    t_word w_tr;

    always_comb begin
        w_tl = rotl(i_slot.left.a + bool_fn(GrpL, i_slot.left.b, i_slot.left.c,
                    i_slot.left.d) + i_slot.w[SelL] + KL, RotL) + i_slot.left.e;
        w_tr = rotl(i_slot.right.a + bool_fn(GrpR, i_slot.right.b, i_slot.right.c,
                    i_slot.right.d) + i_slot.w[SelR] + KR, RotR) + i_slot.right.e;
        n_slot         = i_slot;
        n_slot.left.a  = i_slot.left.e;
        n_slot.left.e  = i_slot.left.d;
        n_slot.left.d  = rotl(i_slot.left.c, 5'd10);
        n_slot.left.c  = i_slot.left.b;
        n_slot.left.b  = w_tl;
        n_slot.right.a = i_slot.right.e;
        n_slot.right.e = i_slot.right.d;
        n_slot.right.d = rotl(i_slot.right.c, 5'd10);
        n_slot.right.c = i_slot.right.b;
        n_slot.right.b = w_tr;
    end

    always_ff @(posedge i_clk) begin
        r_slot.left  <= n_slot.left;
        r_slot.right <= n_slot.right;
        r_slot.w     <= n_slot.w;
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
    end

    assign o_slot = r_slot;
endmodule
`default_nettype wire

/* hw/rtl/ripemd160_single_block_32byte.sv */
// RIPEMD-160 of one 32-byte message, one compression block.
// The message passes through 80 registered round cells, then the registered output add, to o_valid.
// Throughput: one message per cycle; busy is always low, one round per cell.
// Reset: synchronous active low, clears the valid bits of every cell and output.
// Results show on o_valid for one cycle; the receiver cannot stall.
`default_nettype none
module ripemd160_single_block_32byte (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_msg_word_0,
    input  wire logic [31:0] i_msg_word_1,
    input  wire logic [31:0] i_msg_word_2,
    input  wire logic [31:0] i_msg_word_3,
    input  wire logic [31:0] i_msg_word_4,
    input  wire logic [31:0] i_msg_word_5,
    input  wire logic [31:0] i_msg_word_6,
    input  wire logic [31:0] i_msg_word_7,
    output logic             o_valid,
    output logic [31:0]      o_digest_word_0,
    output logic [31:0]      o_digest_word_1,
    output logic [31:0]      o_digest_word_2,
    output logic [31:0]      o_digest_word_3,
    output logic [31:0]      o_digest_word_4
);
    import rmd_pkg::*;

    t_slot w_chain [NumRounds+1];
    t_slot w_head;
    t_line w_iv;

    assign busy = 1'b0;
    assign w_iv = '{a: IV0, b: IV1, c: IV2, d: IV3, e: IV4};

    always_comb begin
        w_head.valid = start;
        w_head.left  = w_iv;
        w_head.right = w_iv;
        w_head.w     = '0;
        w_head.w[0]  = i_msg_word_0;
        w_head.w[1]  = i_msg_word_1;
        w_head.w[2]  = i_msg_word_2;
        w_head.w[3]  = i_msg_word_3;
        w_head.w[4]  = i_msg_word_4;
        w_head.w[5]  = i_msg_word_5;
        w_head.w[6]  = i_msg_word_6;
        w_head.w[7]  = i_msg_word_7;
        w_head.w[8]  = 32'h00000080;   // pad byte
        w_head.w[14] = 32'd256;        // bit length
    end

    assign w_chain[0] = w_head;

    for (genvar g = 0; g < NumRounds; g++) begin : g_cell
        rmd_round_cell #(.ROUND(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_slot  (w_chain[g]),
            .o_slot  (w_chain[g+1])
        );
    end

    t_slot w_last;
    logic  r_valid;
    t_word r_d0, r_d1, r_d2, r_d3, r_d4;

    assign w_last = w_chain[NumRounds];

    always_ff @(posedge i_clk) begin
        r_d0 <= IV1 + w_last.left.c + w_last.right.d;
        r_d1 <= IV2 + w_last.left.d + w_last.right.e;
        r_d2 <= IV3 + w_last.left.e + w_last.right.a;
        r_d3 <= IV4 + w_last.left.a + w_last.right.b;
        r_d4 <= IV0 + w_last.left.b + w_last.right.c;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.valid;
        end
    end

    assign o_valid         = r_valid;
    assign o_digest_word_0 = r_d0;
    assign o_digest_word_1 = r_d1;
    assign o_digest_word_2 = r_d2;
    assign o_digest_word_3 = r_d3;
    assign o_digest_word_4 = r_d4;

    a_first_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> w_chain[1].valid)
        else $error("accepted word did not enter the first cell");
    a_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.valid |=> o_valid)
        else $error("last cell word lost at output");
    a_no_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
endmodule
`default_nettype wire

/* sim/ripemd160_single_block_32byte_test.sv */
`timescale 1ns / 1ps
`default_nettype none
module ripemd160_single_block_32byte_test;
    import rmd_pkg::*;

    localparam int unsigned Latency  = 81;
    localparam int unsigned Watchdog = 5000;

    typedef t_word t_msg [8];
    typedef struct {
        t_word h [5];
    } t_digest;

    // reference hash of one padded 32-byte message
    function automatic t_word rol32(t_word x, int unsigned n);
        n = n % 32;
        if (n == 0) return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_word mix(int unsigned g, t_word x, t_word y, t_word z);
        case (g)
            0:       return x ^ y ^ z;
            1:       return (x & y) | (~x & z);
            2:       return (x | ~y) ^ z;
            3:       return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    function automatic t_digest hash_message(t_msg m);
        t_word   blk [16];
        t_word   al, bl, cl, dl, el, ar, br, cr, dr, er, t;
        int unsigned g;
        t_digest d;
        for (int j = 0; j < 16; j++) blk[j] = (j < 8) ? m[j] : 32'h0;
        blk[8]  = 32'h00000080;
        blk[14] = 32'd256;
        al = IV0; bl = IV1; cl = IV2; dl = IV3; el = IV4;
        ar = IV0; br = IV1; cr = IV2; dr = IV3; er = IV4;
        for (int j = 0; j < 80; j++) begin
            g = j / 16;
            t = rol32(al + mix(g, bl, cl, dl) + blk[SEL_L[j]] + K_L[g], ROT_L[j]) + el;
            al = el; el = dl; dl = rol32(cl, 10); cl = bl; bl = t;
            t = rol32(ar + mix(4 - g, br, cr, dr) + blk[SEL_R[j]] + K_R[g], ROT_R[j]) + er;
            ar = er; er = dr; dr = rol32(cr, 10); cr = br; br = t;
        end
        d.h[0] = IV1 + cl + dr;
        d.h[1] = IV2 + dl + er;
        d.h[2] = IV3 + el + ar;
        d.h[3] = IV4 + al + br;
        d.h[4] = IV0 + bl + cr;
        return d;
    endfunction

    class digest_board;
        t_digest pending [$];
        int      errors = 0;

        function void note_message(t_msg m);
            pending.push_back(hash_message(m));
        endfunction

        function void check_digest(t_digest got);
            t_digest want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest %h %h %h %h %h", $time,
                         got.h[0], got.h[1], got.h[2], got.h[3], got.h[4]);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 5; k++)
                if (got.h[k] !== want.h[k]) begin
                    $display("%0t: digest word %0d expected %h actual %h",
                             $time, k, want.h[k], got.h[k]);
                    errors++;
                end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_word       msg [8];
    logic        o_valid;
    t_word       dig [5];
    digest_board board;
    int          idle_pct = 29;
    int          quiet = 0;

    always #6 i_clk = ~i_clk;

    initial for (int k = 0; k < 8; k++) msg[k] = '0;

    ripemd160_single_block_32byte u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_msg_word_0(msg[0]), .i_msg_word_1(msg[1]), .i_msg_word_2(msg[2]),
        .i_msg_word_3(msg[3]), .i_msg_word_4(msg[4]), .i_msg_word_5(msg[5]),
        .i_msg_word_6(msg[6]), .i_msg_word_7(msg[7]),
        .o_valid(o_valid),
        .o_digest_word_0(dig[0]), .o_digest_word_1(dig[1]), .o_digest_word_2(dig[2]),
        .o_digest_word_3(dig[3]), .o_digest_word_4(dig[4])
    );

    always @(posedge i_clk) begin
        t_digest got;
        t_msg    m;
        if (i_rst_n) begin
            if (start && !busy) begin
                for (int k = 0; k < 8; k++) m[k] = msg[k];
                board.note_message(m);
            end
            if (o_valid) begin
                for (int k = 0; k < 5; k++) got.h[k] = dig[k];
                board.check_digest(got);
            end
            quiet = ((start && !busy) || o_valid) ? 0 : quiet + 1;
            if (quiet >= Watchdog) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // one message word set, held until accepted; random gaps before it
    // start stays high on return so back-to-back words leave no gap
    task automatic send_message(t_msg m);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        for (int k = 0; k < 8; k++) msg[k] = m[k];
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(5))
            0:       return 32'h0;
            1:       return 32'hFFFFFFFF;
            2:       return 32'h1 << $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_msg m;
        board = new();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        // directed: all zeros, all ones, walking words, alternating patterns
        for (int k = 0; k < 8; k++) m[k] = 32'h0;
        send_message(m);
        for (int k = 0; k < 8; k++) m[k] = 32'hFFFFFFFF;
        send_message(m);
        for (int k = 0; k < 8; k++) m[k] = 32'hAAAAAAAA;
        send_message(m);
        for (int k = 0; k < 8; k++) m[k] = 32'h55555555;
        send_message(m);
        for (int j = 0; j < 8; j++) begin
            for (int k = 0; k < 8; k++) m[k] = (k == j) ? 32'hFFFFFFFF : 32'h0;
            send_message(m);
            for (int k = 0; k < 8; k++) m[k] = (k == j) ? 32'h80000001 : 32'h0;
            send_message(m);
        end
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 29 : (ph == 1) ? 45 : 0;
            for (int n = 0; n < 260; n++) begin
                for (int k = 0; k < 8; k++) m[k] = rand_word();
                send_message(m);
            end
            drain();
        end
        repeat (Latency + 10) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/rmd_pkg.sv
hw/rtl/rmd_round_cell.sv
hw/rtl/ripemd160_single_block_32byte.sv
sim/ripemd160_single_block_32byte_test.sv
